// File: design/stcp_pkg.sv
package stcp_pkg;

  localparam int LineCapacity = 24;
  localparam int CountW = $clog2(LineCapacity);

  localparam logic [7:0] ChX     = 8'h58;
  localparam logic [7:0] ChH     = 8'h48;
  localparam logic [7:0] ChT     = 8'h54;
  localparam logic [7:0] ChS     = 8'h53;
  localparam logic [7:0] ChComma = 8'h2C;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChO     = 8'h4F;
  localparam logic [7:0] ChK     = 8'h4B;
  localparam logic [7:0] ChD     = 8'h44;

  localparam logic [1:0] PhFirst  = 2'd0;
  localparam logic [1:0] PhSecond = 2'd1;
  localparam logic [1:0] PhEnd1   = 2'd2;
  localparam logic [1:0] PhEnd2   = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_START,
    ST_PWM,
    ST_CH0,
    ST_CH1,
    ST_CH2,
    ST_WAIT
  } state_t;

  typedef struct packed {
    logic       start;
    logic [23:0] dividend;
    logic [15:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic       busy;
    logic       done;
    logic [23:0] quotient;
  } div_rsp_t;

endpackage

// File: design/serial_tone_command_player_core.sv
// Serial tone command player.
// Input channel (valid/stall): kind selects a received serial byte (0) or a
// one millisecond tick (1). Output channel (valid/stall) carries results:
// a transmit character (out_kind 0) or new pwm settings (out_kind 1); last
// marks the final result caused by one input item.
// half_rate is written through cfg_we/cfg_data; the user must write it only
// while the block is idle, as the block itself does not enforce this. An item
// that causes no result leaves in_stall low. A tone start runs a 24-step
// restoring divider before its results are sent.
// At most 4 results per item. in_stall stays high until the last result of
// the current item is loaded into the output register. A stalled result
// holds in the output register and the sequencer waits. Reset (synchronous)
// clears the line parser, stops any note, and sets half_rate to 1000000.
module serial_tone_command_player_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [23:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        kind,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_kind,
  output logic [7:0]  tx_char,
  output logic [15:0] pwm_period,
  output logic [15:0] pwm_compare,
  output logic        last
);

  logic [23:0] half_rate;
  logic        playing;
  logic [7:0]  command_letter;
  logic [stcp_pkg::CountW-1:0] char_count;
  logic [1:0]  field_phase;
  logic [31:0] first_number;
  logic [31:0] second_number;
  logic [15:0] remaining_ms;
  logic [15:0] period_held;

  // pending work after a single item
  logic [15:0] note_ms;
  logic        note_end;    // emit silence, D, LF
  logic [7:0]  ch0, ch1, ch2;
  logic [1:0]  nchars;

  stcp_pkg::state_t state, state_next;
  stcp_pkg::div_req_t dreq;
  stcp_pkg::div_rsp_t drsp;

  stcp_divider u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  logic accept;
  logic out_free;
  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != stcp_pkg::ST_IDLE);
  assign out_free = !out_valid || !out_stall;

  function automatic logic [31:0] add_digit(input logic [31:0] acc, input logic [3:0] d);
    logic [35:0] v;
    v = {acc, 3'b000} + {2'b00, acc, 1'b0} + {32'd0, d};
    add_digit = (v[35:32] != 4'd0) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  logic is_digit;
  assign is_digit = (rx_byte >= 8'h30) && (rx_byte <= 8'h39);

  logic [15:0] top;
  always_comb begin
    if (drsp.quotient == 24'd0) top = 16'hFFFF;
    else if (drsp.quotient > 24'h010000) top = 16'hFFFF;
    else top = 16'(drsp.quotient - 24'd1);
  end

  always_comb begin
    state_next = state;
    case (state)
      stcp_pkg::ST_IDLE: ;
      stcp_pkg::ST_DIV:   state_next = stcp_pkg::ST_WAIT;
      stcp_pkg::ST_WAIT:  if (drsp.done) state_next = stcp_pkg::ST_START;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= stcp_pkg::ST_IDLE;
      half_rate <= 24'd1000000;
      playing <= 1'b0;
      command_letter <= '0;
      char_count <= '0;
      field_phase <= stcp_pkg::PhFirst;
      first_number <= '0;
      second_number <= '0;
      remaining_ms <= '0;
      period_held <= '0;
      out_valid <= 1'b0;
      note_end <= 1'b0;
      nchars <= '0;
      dreq.start <= 1'b0;
    end else begin
      dreq.start <= 1'b0;
      if (cfg_we) half_rate <= cfg_data;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        stcp_pkg::ST_IDLE: begin
          if (accept) begin
            if (kind) begin
              if (playing && remaining_ms <= 16'd1) begin
                remaining_ms <= '0;
                playing <= 1'b0;
                note_end <= 1'b1;
                state <= stcp_pkg::ST_PWM;
              end else if (playing) begin
                remaining_ms <= remaining_ms - 16'd1;
              end
            end else if (playing) begin
              if (rx_byte == stcp_pkg::ChX) begin
                playing <= 1'b0;
                remaining_ms <= '0;
                note_end <= 1'b0;
                state <= stcp_pkg::ST_PWM;
              end
            end else if (rx_byte == stcp_pkg::ChLf || rx_byte == stcp_pkg::ChCr) begin
              command_letter <= '0;
              char_count <= '0;
              field_phase <= stcp_pkg::PhFirst;
              first_number <= '0;
              second_number <= '0;
              if (char_count != '0) begin
                case (command_letter)
                  stcp_pkg::ChH: begin
                    ch0 <= stcp_pkg::ChO;
                    ch1 <= stcp_pkg::ChK;
                    ch2 <= stcp_pkg::ChLf;
                    nchars <= 2'd3;
                    state <= stcp_pkg::ST_CH0;
                  end
                  stcp_pkg::ChX: begin
                    note_end <= 1'b0;
                    state <= stcp_pkg::ST_PWM;
                  end
                  stcp_pkg::ChT: begin
                    note_ms <= (field_phase == stcp_pkg::PhSecond ||
                                field_phase == stcp_pkg::PhEnd2) ?
                               second_number[15:0] : 16'd0;
                    if (first_number[15:0] == 16'd0) begin
                      note_end <= 1'b0;
                      state <= stcp_pkg::ST_START;
                      dreq.divisor <= 16'd0;
                    end else begin
                      dreq.start <= 1'b1;
                      dreq.dividend <= half_rate;
                      dreq.divisor <= first_number[15:0];
                      state <= stcp_pkg::ST_DIV;
                    end
                  end
                  stcp_pkg::ChS: begin
                    note_ms <= first_number[15:0];
                    dreq.divisor <= 16'd0;
                    state <= stcp_pkg::ST_START;
                  end
                  default: ;
                endcase
              end
            end else if (32'(char_count) < stcp_pkg::LineCapacity - 1) begin
              char_count <= char_count + 1'b1;
              if (char_count == '0) command_letter <= rx_byte;
              else if (command_letter == stcp_pkg::ChT || command_letter == stcp_pkg::ChS) begin
                if (field_phase == stcp_pkg::PhFirst) begin
                  if (is_digit) first_number <= add_digit(first_number, rx_byte[3:0]);
                  else if (rx_byte == stcp_pkg::ChComma && command_letter == stcp_pkg::ChT)
                    field_phase <= stcp_pkg::PhSecond;
                  else field_phase <= stcp_pkg::PhEnd1;
                end else if (field_phase == stcp_pkg::PhSecond) begin
                  if (is_digit) second_number <= add_digit(second_number, rx_byte[3:0]);
                  else field_phase <= stcp_pkg::PhEnd2;
                end
              end
            end
          end
        end
        stcp_pkg::ST_DIV, stcp_pkg::ST_WAIT: state <= state_next;
        stcp_pkg::ST_START: begin
          // tone or silence start result
          if (out_free) begin
            out_valid <= 1'b1;
            out_kind <= 1'b1;
            tx_char <= '0;
            if (dreq.divisor != 16'd0) begin
              period_held <= top;
              pwm_period <= top;
              pwm_compare <= {1'b0, top[15:1]};
            end else begin
              pwm_period <= period_held;
              pwm_compare <= '0;
            end
            if (note_ms == 16'd0) begin
              last <= 1'b0;
              playing <= 1'b0;
              remaining_ms <= '0;
              note_end <= 1'b1;
              state <= stcp_pkg::ST_PWM;
            end else begin
              last <= 1'b1;
              playing <= 1'b1;
              remaining_ms <= note_ms;
              state <= stcp_pkg::ST_IDLE;
            end
            dreq.divisor <= 16'd0;
          end
        end
        stcp_pkg::ST_PWM: begin
          // silence result; a note end adds D and LF
          if (out_free) begin
            out_valid <= 1'b1;
            out_kind <= 1'b1;
            tx_char <= '0;
            pwm_period <= period_held;
            pwm_compare <= '0;
            last <= !note_end;
            if (note_end) begin
              ch0 <= stcp_pkg::ChD;
              ch1 <= stcp_pkg::ChLf;
              nchars <= 2'd2;
              note_end <= 1'b0;
              state <= stcp_pkg::ST_CH0;
            end else state <= stcp_pkg::ST_IDLE;
          end
        end
        stcp_pkg::ST_CH0, stcp_pkg::ST_CH1, stcp_pkg::ST_CH2: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_kind <= 1'b0;
            tx_char <= ch0;
            pwm_period <= '0;
            pwm_compare <= '0;
            last <= (nchars == 2'd1);
            ch0 <= ch1;
            ch1 <= ch2;
            nchars <= nchars - 2'd1;
            state <= (nchars == 2'd1) ? stcp_pkg::ST_IDLE : stcp_pkg::ST_CH1;
          end
        end
        default: state <= stcp_pkg::ST_IDLE;
      endcase
    end
  end

  a_stall_busy: assert property (@(posedge clk) disable iff (rst)
    (state != stcp_pkg::ST_IDLE) |-> in_stall) else $error("accepting while busy");
  a_div_once: assert property (@(posedge clk) disable iff (rst)
    drsp.done |-> state == stcp_pkg::ST_WAIT) else $error("divider done out of turn");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid && $stable(tx_char) && $stable(pwm_period))
    else $error("result lost under stall");
  a_playing_ms: assert property (@(posedge clk) disable iff (rst)
    (playing && state == stcp_pkg::ST_IDLE) |-> remaining_ms != 16'd0)
    else $error("playing with zero time");

endmodule

// File: design/stcp_divider.sv
module stcp_divider (
  input  logic               clk,
  input  logic               rst,
  input  stcp_pkg::div_req_t req,
  output stcp_pkg::div_rsp_t rsp
);

  logic [23:0] quo;
  logic [16:0] rem;
  logic [15:0] dsr;
  logic [4:0]  cnt;
  logic        busy;
  logic        done;
  logic [16:0] trial;
  logic [16:0] shifted;

  assign shifted = {rem[15:0], quo[23]};
  assign trial   = shifted - {1'b0, dsr};

  // restoring division, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        quo  <= req.dividend;
        dsr  <= req.divisor;
        rem  <= '0;
        cnt  <= 5'd24;
      end else if (busy) begin
        if (!trial[16]) begin
          rem <= trial;
          quo <= {quo[22:0], 1'b1};
        end else begin
          rem <= shifted;
          quo <= {quo[22:0], 1'b0};
        end
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy     = busy;
  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

// File: test/serial_tone_command_player_core_tb.sv
module serial_tone_command_player_core_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LastCol = stcp_pkg::LineCapacity - 1;
  localparam int LinesPerPhase = 2;

  typedef struct packed {
    logic        out_kind;
    logic [7:0]  tx_char;
    logic [15:0] pwm_period;
    logic [15:0] pwm_compare;
    logic        last;
  } tone_result_t;

  typedef struct {
    logic       kind;
    logic [7:0] rx_byte;
    int         n_typed;
    tone_result_t typed[4];
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [23:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        kind = 1'b0;
  logic [7:0]  rx_byte = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_kind;
  logic [7:0]  tx_char;
  logic [15:0] pwm_period;
  logic [15:0] pwm_compare;
  logic        last;

  serial_tone_command_player_core i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .kind(kind), .rx_byte(rx_byte),
    .out_valid(out_valid), .out_stall(out_stall), .out_kind(out_kind),
    .tx_char(tx_char), .pwm_period(pwm_period), .pwm_compare(pwm_compare),
    .last(last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predictor state
  logic [23:0] half_rate_q;
  logic        playing_q;
  logic [7:0]  letter_q;
  int unsigned count_q;
  logic [1:0]  phase_q;
  logic [31:0] first_q;
  logic [31:0] second_q;
  logic [15:0] remain_q;
  logic [15:0] period_q;

  tone_result_t expected_results[$];
  int  failures = 0;
  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  bit  hold_off = 1'b0;

  function automatic tone_result_t pwm_res(logic [15:0] per, logic [15:0] cmp);
    tone_result_t r;
    r = '{1'b1, 8'h00, per, cmp, 1'b0};
    return r;
  endfunction

  function automatic tone_result_t char_res(logic [7:0] ch);
    tone_result_t r;
    r = '{1'b0, ch, 16'h0, 16'h0, 1'b0};
    return r;
  endfunction

  function automatic logic [31:0] sat_digit(logic [31:0] acc, logic [7:0] c);
    logic [35:0] v;
    v = 36'(acc) * 10 + 36'(c - "0");
    return (v > 36'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  task automatic end_note(inout tone_result_t res[$]);
    playing_q = 1'b0;
    remain_q = '0;
    res.push_back(pwm_res(period_q, 16'h0));
    res.push_back(char_res(stcp_pkg::ChD));
    res.push_back(char_res(stcp_pkg::ChLf));
  endtask

  task automatic begin_note(inout tone_result_t res[$], input logic [15:0] freq,
                            input logic [15:0] ms);
    logic [23:0] q;
    if (freq == 0) begin
      res.push_back(pwm_res(period_q, 16'h0));
    end else begin
      q = half_rate_q / freq;
      period_q = (q == 0 || q > 24'h10000) ? 16'hFFFF : 16'(q - 1);
      res.push_back(pwm_res(period_q, period_q >> 1));
    end
    if (ms == 0) begin
      end_note(res);
    end else begin
      playing_q = 1'b1;
      remain_q = ms;
    end
  endtask

  task automatic clear_line();
    letter_q = '0;
    count_q = 0;
    phase_q = stcp_pkg::PhFirst;
    first_q = '0;
    second_q = '0;
  endtask

  task automatic reset_model();
    half_rate_q = 24'd1000000;
    playing_q = 1'b0;
    remain_q = '0;
    period_q = '0;
    clear_line();
  endtask

  task automatic predict_tone(logic k, logic [7:0] c, output tone_result_t res[$]);
    bit is_digit;
    res = {};
    is_digit = (c >= "0" && c <= "9");
    if (k) begin
      if (playing_q) begin
        if (remain_q > 0) remain_q--;
        if (remain_q == 0) end_note(res);
      end
    end else if (playing_q) begin
      if (c == stcp_pkg::ChX) begin
        playing_q = 1'b0;
        remain_q = '0;
        res.push_back(pwm_res(period_q, 16'h0));
      end
    end else if (c == stcp_pkg::ChLf || c == stcp_pkg::ChCr) begin
      if (count_q > 0) begin
        case (letter_q)
          stcp_pkg::ChH: begin
            res.push_back(char_res(stcp_pkg::ChO));
            res.push_back(char_res(stcp_pkg::ChK));
            res.push_back(char_res(stcp_pkg::ChLf));
          end
          stcp_pkg::ChX: res.push_back(pwm_res(period_q, 16'h0));
          stcp_pkg::ChT: begin_note(res, first_q[15:0],
                 (phase_q == stcp_pkg::PhSecond || phase_q == stcp_pkg::PhEnd2) ?
                 second_q[15:0] : 16'h0);
          stcp_pkg::ChS: begin_note(res, 16'h0, first_q[15:0]);
          default: ;
        endcase
      end
      clear_line();
    end else if (count_q < LastCol) begin
      if (count_q == 0) begin
        letter_q = c;
      end else if (letter_q == stcp_pkg::ChT || letter_q == stcp_pkg::ChS) begin
        if (phase_q == stcp_pkg::PhFirst) begin
          if (is_digit) first_q = sat_digit(first_q, c);
          else if (c == stcp_pkg::ChComma && letter_q == stcp_pkg::ChT)
            phase_q = stcp_pkg::PhSecond;
          else phase_q = stcp_pkg::PhEnd1;
        end else if (phase_q == stcp_pkg::PhSecond) begin
          if (is_digit) second_q = sat_digit(second_q, c);
          else phase_q = stcp_pkg::PhEnd2;
        end
      end
      count_q++;
    end
    if (res.size() > 0) res[res.size() - 1].last = 1'b1;
  endtask

  // Send one item, checking typed results against the predictor if given
  task automatic send_item(logic k, logic [7:0] c, int n_typed = -1,
                           tone_result_t typed[4] = '{default: '0});
    tone_result_t res[$];
    predict_tone(k, c, res);
    if (n_typed >= 0) begin
      if (n_typed != res.size()) begin
        $display("%0t: typed count mismatch expected %0d actual %0d",
                 $time, n_typed, res.size());
        failures++;
      end else begin
        foreach (res[i])
          if (res[i] !== typed[i]) begin
            $display("%0t: typed row mismatch expected %h actual %h",
                     $time, typed[i], res[i]);
            failures++;
          end
      end
    end
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    foreach (res[i]) expected_results.push_back(res[i]);
    in_valid <= 1'b1;
    kind <= k;
    rx_byte <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_text(string s);
    foreach (s[i]) send_item(1'b0, s[i]);
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (expected_results.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_half_rate(logic [23:0] v);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    half_rate_q = v;
  endtask

  task automatic send_number(int unsigned v);
    string s;
    s.itoa(v);
    send_text(s);
  endtask

  task automatic random_line();
    int unsigned sel;
    int unsigned ticks;
    sel = $urandom_range(9);
    case (sel)
      0: send_text("H");
      1: send_text("X");
      2, 3, 4: begin
        send_text("T");
        send_number($urandom_range(4) == 0 ? $urandom : $urandom_range(3000));
        if ($urandom_range(5) != 0) begin
          send_text(",");
          send_number($urandom_range(6));
        end
      end
      5, 6: begin
        send_text("S");
        send_number($urandom_range(5));
      end
      default: begin
        repeat ($urandom_range(1, 28)) send_item(1'b0, 8'($urandom));
      end
    endcase
    send_item(1'b0, $urandom_range(1) ? stcp_pkg::ChLf : stcp_pkg::ChCr);
    // Play out or break the note
    ticks = $urandom_range(7);
    repeat (ticks) begin
      if ($urandom_range(9) == 0)
        send_item(1'b0, $urandom_range(1) ? stcp_pkg::ChX : 8'($urandom));
      else send_item(1'b1, 8'($urandom));
    end
  endtask

  // Directed table
  stim_row_t dir_rows[$];

  function automatic stim_row_t row(logic k, logic [7:0] c, int n = -1,
                                    tone_result_t a = '0, tone_result_t b = '0,
                                    tone_result_t d = '0, tone_result_t e = '0);
    stim_row_t r;
    r.kind = k;
    r.rx_byte = c;
    r.n_typed = n;
    r.typed = '{a, b, d, e};
    return r;
  endfunction

  function automatic tone_result_t fin(tone_result_t r);
    r.last = 1'b1;
    return r;
  endfunction

  initial begin
    string txt;
    dir_rows.push_back(row(1'b1, 8'hFF, 0));
    dir_rows.push_back(row(1'b0, stcp_pkg::ChLf, 0));
    dir_rows.push_back(row(1'b0, stcp_pkg::ChH));
    dir_rows.push_back(row(1'b0, stcp_pkg::ChCr, 3, char_res(stcp_pkg::ChO),
                           char_res(stcp_pkg::ChK), fin(char_res(stcp_pkg::ChLf))));
    dir_rows.push_back(row(1'b0, stcp_pkg::ChX));
    dir_rows.push_back(row(1'b0, stcp_pkg::ChLf, 1, fin(pwm_res(16'h0, 16'h0))));
    // T0 with no comma: zero freq and zero duration
    dir_rows.push_back(row(1'b0, stcp_pkg::ChT));
    dir_rows.push_back(row(1'b0, "0"));
    dir_rows.push_back(row(1'b0, stcp_pkg::ChLf, 4, pwm_res(16'h0, 16'h0),
                           pwm_res(16'h0, 16'h0), char_res(stcp_pkg::ChD),
                           fin(char_res(stcp_pkg::ChLf))));
    // T1,1 saturates the period, then one tick ends it
    txt = "T1,1";
    foreach (txt[i]) dir_rows.push_back(row(1'b0, txt[i]));
    dir_rows.push_back(row(1'b0, stcp_pkg::ChLf, 1, fin(pwm_res(16'hFFFF, 16'h7FFF))));
    dir_rows.push_back(row(1'b0, 8'h00, 0));
    dir_rows.push_back(row(1'b1, 8'h00, 3, pwm_res(16'hFFFF, 16'h0),
                           char_res(stcp_pkg::ChD), fin(char_res(stcp_pkg::ChLf))));
    // S9 aborted by X
    dir_rows.push_back(row(1'b0, stcp_pkg::ChS));
    dir_rows.push_back(row(1'b0, "9"));
    dir_rows.push_back(row(1'b0, stcp_pkg::ChLf, 1, fin(pwm_res(16'hFFFF, 16'h0))));
    dir_rows.push_back(row(1'b0, stcp_pkg::ChX, 1, fin(pwm_res(16'hFFFF, 16'h0))));
    dir_rows.push_back(row(1'b1, 8'h00, 0));
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    reset_model();

    foreach (dir_rows[i])
      send_item(dir_rows[i].kind, dir_rows[i].rx_byte, dir_rows[i].n_typed,
                dir_rows[i].typed);
    // Overlong line and saturating field
    send_text("T99999999999999999999,3");
    send_text("777777");
    send_item(1'b0, stcp_pkg::ChLf);
    repeat (3) send_item(1'b1, 8'h00);
    wait_drain();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin write_half_rate(24'd1); send_idle_pct = 26; recv_idle_pct = 65; end
        1: begin write_half_rate(24'hFFFFFF); send_idle_pct = 65; recv_idle_pct = 26; end
        default: begin write_half_rate(24'd1000000); send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      if (phase == 2) begin
        hold_off = 1'b1;
        repeat (4) begin
          send_text("H");
          send_item(1'b0, stcp_pkg::ChLf);
        end
        hold_off = 1'b0;
      end
      for (int n = 0; n < LinesPerPhase; n++) random_line();
      // Stop any note so the write happens while idle
      send_item(1'b0, stcp_pkg::ChX);
      wait_drain();
    end

    if (failures == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  // Receiver
  int hold_cnt = 0;
  always @(posedge clk) begin
    if (hold_off && hold_cnt < 200) begin
      hold_cnt <= hold_cnt + 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= (recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    tone_result_t got;
    tone_result_t want;
    if (!rst && out_valid && !out_stall) begin
      got = '{out_kind, tx_char, pwm_period, pwm_compare, last};
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result expected none actual %h", $time, got);
        failures++;
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          $display("%0t: result mismatch expected %h actual %h", $time, want, got);
          failures++;
        end
      end
    end
  end

  initial begin
    #2ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule
